// ----- design/pkd_pkg.sv -----
// Shared constants and types for the key derivation core.
`default_nettype none
package pkd_pkg;

    localparam int KEY_BYTES  = 16;
    localparam int KEY_W      = KEY_BYTES * 8;
    localparam int IDX_W      = $clog2(KEY_BYTES);
    localparam int LANES      = 4;
    localparam int HEX_CHARS  = 32;
    localparam int NIB_IDX_W  = $clog2(HEX_CHARS);
    localparam int COUNT_W    = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] HEX_COUNT = COUNT_W'(HEX_CHARS);

    // One finished key waiting to be serialised.
    typedef struct packed {
        logic             from_hex;
        logic [KEY_W-1:0] key;
    } key_entry_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

// ----- design/psk_key_derivation_core.sv -----
// Top level of the key derivation core: front end, key queue and serialiser.
`default_nettype none
// The core takes a key string one character per input transaction and accepts a
// character every cycle, hashing it into four 32-bit lanes as it arrives. The
// transaction marked end_of_text (with or without a character) closes the string:
// the finished 16-byte key, either the decoded hex pairs of an exactly 32-digit hex
// string or the four hash lanes little-endian, is placed in a two-entry queue and
// the running state restarts at once for the next string. The serialiser sends each
// key as 16 output transactions, one per cycle while m_ready is high. A key stays
// in the queue until its final byte has been loaded for output, so input stalls
// only while two finished keys are held: the one being sent and one waiting
// behind it.
module psk_key_derivation_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_text_char,
    input  wire logic        s_has_char,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_byte_index,
    output logic [7:0]       m_key_byte,
    output logic             m_from_hex,
    output logic             m_last_byte
);

    logic                   push, pop;
    pkd_pkg::key_entry_t    push_entry, head;
    pkd_pkg::queue_status_t q_status;

    pkd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_char   (s_text_char),
        .s_has_char    (s_has_char),
        .s_end_of_text (s_end_of_text),
        .q_status      (q_status),
        .push          (push),
        .push_entry    (push_entry)
    );

    pkd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    pkd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_byte_index (m_byte_index),
        .m_key_byte   (m_key_byte),
        .m_from_hex   (m_from_hex),
        .m_last_byte  (m_last_byte)
    );

    // A closing transaction must always find room in the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("end of string accepted with the key queue full");

    // The queue can never report full and empty together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("key queue reports full and empty at once");

    // Within a key the bytes follow each other without a gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_byte) |=>
            (m_valid && m_byte_index == $past(m_byte_index) + 4'd1))
        else $error("key bytes out of sequence");

    // A key is only released from the queue when its final byte is loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (m_valid && m_last_byte))
        else $error("key released before its final byte");

endmodule
`default_nettype wire

// ----- design/pkd_front.sv -----
// Front end: takes characters, keeps the running hashes and nibbles, builds the key.
`default_nettype none
module pkd_front (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_text_char,
    input  wire logic                  s_has_char,
    input  wire logic                  s_end_of_text,
    input  wire pkd_pkg::queue_status_t q_status,
    output logic                       push,
    output pkd_pkg::key_entry_t        push_entry
);

    logic [pkd_pkg::COUNT_W-1:0] count_reg, count_next, count_upd;
    logic                        all_hex_reg, all_hex_next, all_hex_upd;
    logic [31:0]                 lane_reg [pkd_pkg::LANES];
    logic [31:0]                 lane_next [pkd_pkg::LANES];
    logic [31:0]                 lane_upd [pkd_pkg::LANES];
    logic [3:0]                  nib_reg [pkd_pkg::HEX_CHARS];
    logic [3:0]                  nib_upd [pkd_pkg::HEX_CHARS];
    logic                        accept, take, is_hex, nib_wr;
    logic [3:0]                  nib_val;
    logic [pkd_pkg::KEY_W-1:0]   hex_key, hash_key;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign take    = accept && s_has_char;

    always_comb begin
        is_hex  = 1'b1;
        nib_val = 4'd0;
        if (s_text_char >= 8'h30 && s_text_char <= 8'h39) begin
            nib_val = s_text_char[3:0];
        end else if ((s_text_char >= 8'h61 && s_text_char <= 8'h66) ||
                     (s_text_char >= 8'h41 && s_text_char <= 8'h46)) begin
            nib_val = 4'(s_text_char[2:0] + 3'd1) + 4'd8;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign nib_wr = take && is_hex && (count_reg < pkd_pkg::HEX_COUNT);

    always_comb begin
        count_upd   = count_reg;
        all_hex_upd = all_hex_reg;
        for (int k = 0; k < pkd_pkg::LANES; k++) begin
            lane_upd[k] = lane_reg[k];
        end
        for (int j = 0; j < pkd_pkg::HEX_CHARS; j++) begin
            nib_upd[j] = nib_reg[j];
        end
        if (take) begin
            if (!is_hex) begin
                all_hex_upd = 1'b0;
            end
            if (count_reg != pkd_pkg::COUNT_MAX) begin
                count_upd = count_reg + 1'b1;
            end
            for (int k = 0; k < pkd_pkg::LANES; k++) begin
                lane_upd[k] = {lane_reg[k][26:0], 5'd0} + lane_reg[k]
                              + {24'd0, s_text_char} + 32'(k);
            end
        end
        if (nib_wr) begin
            nib_upd[count_reg[pkd_pkg::NIB_IDX_W-1:0]] = nib_val;
        end
    end

    // Byte i of the key sits at bits [8i+7:8i].
    always_comb begin
        for (int i = 0; i < pkd_pkg::KEY_BYTES; i++) begin
            hex_key[8*i +: 8] = {nib_upd[2*i], nib_upd[2*i+1]};
        end
        for (int k = 0; k < pkd_pkg::LANES; k++) begin
            hash_key[32*k +: 32] = lane_upd[k];
        end
    end

    assign push                = accept && s_end_of_text;
    assign push_entry.from_hex = all_hex_upd && (count_upd == pkd_pkg::HEX_COUNT);
    assign push_entry.key      = push_entry.from_hex ? hex_key : hash_key;

    // The end of a string returns the count, the hex flag and every hash lane to its starting point.
    always_comb begin
        if (push) begin
            count_next   = '0;
            all_hex_next = 1'b1;
            for (int k = 0; k < pkd_pkg::LANES; k++) begin
                lane_next[k] = pkd_pkg::HASH_SEED;
            end
        end else begin
            count_next   = count_upd;
            all_hex_next = all_hex_upd;
            for (int k = 0; k < pkd_pkg::LANES; k++) begin
                lane_next[k] = lane_upd[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            all_hex_reg <= 1'b1;
            for (int k = 0; k < pkd_pkg::LANES; k++) begin
                lane_reg[k] <= pkd_pkg::HASH_SEED;
            end
        end else begin
            count_reg   <= count_next;
            all_hex_reg <= all_hex_next;
            for (int k = 0; k < pkd_pkg::LANES; k++) begin
                lane_reg[k] <= lane_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (nib_wr) begin
            nib_reg[count_reg[pkd_pkg::NIB_IDX_W-1:0]] <= nib_val;
        end
    end

endmodule
`default_nettype wire

// ----- design/pkd_queue.sv -----
// Short queue of finished keys between the front end and the serialiser.
`default_nettype none
module pkd_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire pkd_pkg::key_entry_t    push_entry,
    input  wire logic                   pop,
    output pkd_pkg::key_entry_t         head,
    output pkd_pkg::queue_status_t      status
);

    pkd_pkg::key_entry_t          mem [pkd_pkg::QUEUE_DEPTH];
    logic [pkd_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pkd_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pkd_pkg::QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                         do_push, do_pop;

    assign status.full  = (cnt_reg == pkd_pkg::QCNT_W'(pkd_pkg::QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == pkd_pkg::QPTR_W'(pkd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == pkd_pkg::QPTR_W'(pkd_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ----- design/pkd_back.sv -----
// Serialiser: sends the queued key out one byte per transaction.
`default_nettype none
module pkd_back (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire pkd_pkg::key_entry_t       head,
    input  wire pkd_pkg::queue_status_t    q_status,
    output logic                           pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [pkd_pkg::IDX_W-1:0]      m_byte_index,
    output logic [7:0]                     m_key_byte,
    output logic                           m_from_hex,
    output logic                           m_last_byte
);

    localparam logic [pkd_pkg::IDX_W-1:0] LAST_IDX = pkd_pkg::IDX_W'(pkd_pkg::KEY_BYTES - 1);

    logic [pkd_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      m_valid_reg, m_valid_next;
    logic [pkd_pkg::IDX_W-1:0] m_byte_index_reg;
    logic [7:0]                m_key_byte_reg;
    logic                      m_from_hex_reg, m_last_byte_reg;
    logic                      load;

    // The output register refills in the same cycle that its byte is taken, if the queue holds a key.
    assign load = (!m_valid_reg || m_ready) && !q_status.empty;
    assign pop  = load && (idx_reg == LAST_IDX);

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            idx_next     = idx_reg + 1'b1;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_byte_index_reg <= idx_reg;
            m_key_byte_reg   <= head.key[8*idx_reg +: 8];
            m_from_hex_reg   <= head.from_hex;
            m_last_byte_reg  <= (idx_reg == LAST_IDX);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_byte_index = m_byte_index_reg;
    assign m_key_byte   = m_key_byte_reg;
    assign m_from_hex   = m_from_hex_reg;
    assign m_last_byte  = m_last_byte_reg;

endmodule
`default_nettype wire
